// ----- hdl/prps_pkg.sv -----
package prps_pkg;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // store the accepted sample
		logic srch_init;  // latch the sample count and the order range
		logic ord_init;   // start a trial order
		logic part_init;  // start a partition: clear sums, set up pass one
		logic pass_init;  // set up pass two and preload the k * size term
		logic pass_go;    // stream samples through the active pass
		logic pass2;      // active pass is the cost pass
		logic k_step;     // try the next Rice parameter
		logic part_done;  // book the partition code and cost
		logic order_done; // compare the trial total against the best one
		logic emit_init;  // restart the result counter
		logic emit_next;  // advance to the next result word
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pass_done;
		logic k_done;
		logic blank;
		logic last_part;
		logic last_order;
		logic emit_last;
	} sts_t;

	localparam int unsigned CFG_MIN_ORDER  = 0;
	localparam int unsigned CFG_MAX_ORDER  = 1;
	localparam int unsigned CFG_RICE_MAX   = 2;
	localparam int unsigned CFG_BLANK_CODE = 3;
	localparam int unsigned CFG_EPB        = 4;
	localparam int unsigned CFG_OFB        = 5;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 5;
	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned CODE_W     = 5;
	localparam int unsigned INDEX_W    = 4;

	// Adds a 33-bit increment to a 32-bit sum and clamps at all ones.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
		logic [33:0] s;
		s = {2'b00, a} + {1'b0, b};
		return (s[33:32] != 2'b00) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ----- hdl/prps_ctrl.sv -----
module prps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  prps_pkg::sts_t sts,
	output prps_pkg::cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_LOAD  = 10'b00_0000_0001,
		ST_INIT  = 10'b00_0000_0010,
		ST_ORD   = 10'b00_0000_0100,
		ST_PART  = 10'b00_0000_1000,
		ST_P1    = 10'b00_0001_0000,
		ST_KS    = 10'b00_0010_0000,
		ST_P2    = 10'b00_0100_0000,
		ST_PDONE = 10'b00_1000_0000,
		ST_ODONE = 10'b01_0000_0000,
		ST_EMIT  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.srch_init = 1'b1;
				state_d       = ST_ORD;
			end
			ST_ORD: begin
				cmd.ord_init = 1'b1;
				state_d      = ST_PART;
			end
			ST_PART: begin
				cmd.part_init = 1'b1;
				state_d       = ST_P1;
			end
			ST_P1: begin
				cmd.pass_go = 1'b1;
				if (sts.pass_done) begin
					state_d = sts.blank ? ST_PDONE : ST_KS;
				end
			end
			ST_KS: begin
				if (sts.k_done) begin
					cmd.pass_init = 1'b1;
					state_d       = ST_P2;
				end else begin
					cmd.k_step = 1'b1;
				end
			end
			ST_P2: begin
				cmd.pass_go = 1'b1;
				cmd.pass2   = 1'b1;
				if (sts.pass_done) begin
					state_d = ST_PDONE;
				end
			end
			ST_PDONE: begin
				cmd.part_done = 1'b1;
				state_d       = sts.last_part ? ST_ODONE : ST_PART;
			end
			ST_ODONE: begin
				cmd.order_done = 1'b1;
				if (sts.last_order) begin
					cmd.emit_init = 1'b1;
					state_d       = ST_EMIT;
				end else begin
					state_d = ST_ORD;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.emit_next = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output channels open at once");

	a_last_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && sts.emit_last) |=> in_ready)
		else $error("block did not return to loading after the final word");

	a_last_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last) |=> !in_ready && !out_valid)
		else $error("final sample did not start the search");

endmodule

// ----- hdl/prps_dp.sv -----
module prps_dp #(
	parameter int unsigned MAX_SAMPLES = 4096,
	parameter int unsigned MAX_ORDER   = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [prps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [prps_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [prps_pkg::SAMPLE_W-1:0]        sample,
	input  prps_pkg::cmd_t                       cmd,
	output prps_pkg::sts_t                       sts,
	output logic                                 kind,
	output logic [prps_pkg::INDEX_W-1:0]         index,
	output logic [prps_pkg::CODE_W-1:0]          value,
	output logic [31:0]                          bit_total,
	output logic                                 last_result
);

	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned AW = $clog2(MAX_SAMPLES);
	localparam int unsigned SW = prps_pkg::SAMPLE_W + CW;
	localparam int unsigned OW = $clog2(MAX_ORDER + 1);
	localparam int unsigned PW = MAX_ORDER;
	localparam int unsigned PN = 1 << MAX_ORDER;
	localparam int unsigned EW = MAX_ORDER + 1;

	// Configuration registers.
	logic [2:0] min_order_q, max_order_q, epb_q, ofb_q;
	logic [4:0] rice_max_q, blank_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_order_q  <= 3'd0;
			max_order_q  <= 3'd3;
			rice_max_q   <= 5'd14;
			blank_code_q <= 5'd15;
			epb_q        <= 3'd4;
			ofb_q        <= 3'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				3'(prps_pkg::CFG_MIN_ORDER):  min_order_q  <= cfg_data[2:0];
				3'(prps_pkg::CFG_MAX_ORDER):  max_order_q  <= cfg_data[2:0];
				3'(prps_pkg::CFG_RICE_MAX):   rice_max_q   <= cfg_data;
				3'(prps_pkg::CFG_BLANK_CODE): blank_code_q <= cfg_data;
				3'(prps_pkg::CFG_EPB):        epb_q        <= cfg_data[2:0];
				3'(prps_pkg::CFG_OFB):        ofb_q        <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Sample memory, one write and one registered read.
	logic [prps_pkg::SAMPLE_W-1:0] mem [MAX_SAMPLES];
	logic [CW-1:0] count_q, n_q, addr_q, rem_q, start_q;
	logic [prps_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic pend_s1, issue, store_ok;

	assign store_ok = cmd.load && (count_q < CW'(MAX_SAMPLES));
	assign issue    = cmd.pass_go && (rem_q != '0);

	always_ff @(posedge clk) begin
		if (store_ok) begin
			mem[count_q[AW-1:0]] <= sample;
		end
		if (issue) begin
			rd_data_s1 <= mem[addr_q[AW-1:0]];
		end
	end

	// Search state.
	logic [OW-1:0] order_q, hi_q, best_order_q;
	logic [PW-1:0] part_q;
	logic [SW-1:0] abs_sum_q;
	logic          blank_q, first_q;
	logic [4:0]    k_q;
	logic [31:0]   cost_q, total_q, best_total_q;
	logic [EW-1:0] e_q;
	logic [prps_pkg::CODE_W-1:0] trial_q [PN];
	logic [prps_pkg::CODE_W-1:0] best_q  [PN];

	logic [CW-1:0] size;
	logic [2:0]    lo_c, hi_c;
	logic [31:0]   mag, zz;
	logic [31:0]   part_cost;

	assign size = n_q >> order_q;
	assign lo_c = (min_order_q > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : min_order_q;
	assign hi_c = (max_order_q > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : max_order_q;
	assign mag  = rd_data_s1[31] ? (32'd0 - rd_data_s1) : rd_data_s1;
	assign zz   = {rd_data_s1[30:0], 1'b0} ^ {32{rd_data_s1[31]}};
	assign part_cost = blank_q ? 32'(epb_q) : cost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pend_s1      <= 1'b0;
			best_total_q <= 32'hFFFF_FFFF;
			best_order_q <= '0;
			e_q          <= '0;
		end else begin
			pend_s1 <= issue;
			if (store_ok) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.srch_init) begin
				count_q <= '0;
			end
			if (cmd.order_done && (first_q || (total_q < best_total_q))) begin
				best_total_q <= total_q;
				best_order_q <= order_q;
			end
			if (cmd.emit_init) begin
				e_q <= '0;
			end else if (cmd.emit_next) begin
				e_q <= e_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			n_q     <= count_q;
			order_q <= OW'(lo_c);
			hi_q    <= (hi_c < lo_c) ? OW'(lo_c) : OW'(hi_c);
			first_q <= 1'b1;
		end
		if (cmd.ord_init) begin
			total_q <= 32'(ofb_q);
			part_q  <= '0;
			start_q <= '0;
		end
		if (cmd.part_init) begin
			abs_sum_q <= '0;
			blank_q   <= 1'b1;
			k_q       <= '0;
			addr_q    <= start_q;
			rem_q     <= size;
		end else if (cmd.pass_init) begin
			addr_q <= start_q;
			rem_q  <= size;
			cost_q <= 32'(k_q) * 32'(size);
		end else if (issue) begin
			addr_q <= addr_q + 1'b1;
			rem_q  <= rem_q - 1'b1;
		end
		if (cmd.k_step) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.pass_go && pend_s1) begin
			if (cmd.pass2) begin
				cost_q <= prps_pkg::sat_add(cost_q, {1'b0, zz >> k_q} + 33'd1);
			end else begin
				abs_sum_q <= abs_sum_q + SW'(mag);
				if (rd_data_s1 != '0) begin
					blank_q <= 1'b0;
				end
			end
		end
		if (cmd.part_done) begin
			trial_q[part_q] <= blank_q ? blank_code_q : k_q;
			total_q         <= prps_pkg::sat_add(total_q, {1'b0, part_cost});
			part_q          <= part_q + 1'b1;
			start_q         <= start_q + size;
		end
		if (cmd.order_done) begin
			if (first_q || (total_q < best_total_q)) begin
				best_q <= trial_q;
			end
			first_q <= 1'b0;
			order_q <= order_q + 1'b1;
		end
	end

	// Status.
	logic [EW-1:0] e_m1;

	assign sts.pass_done  = (rem_q == '0) && !pend_s1;
	assign sts.k_done     = (abs_sum_q < (SW'(size) << k_q)) || (k_q == rice_max_q);
	assign sts.blank      = blank_q;
	assign sts.last_part  = (32'(part_q) + 32'd1) == (32'd1 << order_q);
	assign sts.last_order = order_q >= hi_q;
	assign sts.emit_last  = 32'(e_q) == (32'd1 << best_order_q);

	// Result word.
	assign e_m1        = e_q - 1'b1;
	assign kind        = (e_q != '0);
	assign index       = kind ? prps_pkg::INDEX_W'(e_m1) : '0;
	assign value       = kind ? best_q[e_m1[PW-1:0]] : prps_pkg::CODE_W'(best_order_q);
	assign bit_total   = kind ? 32'd0 : best_total_q;
	assign last_result = kind && sts.emit_last;

	a_first_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.order_done && first_q) |=> (best_order_q == $past(order_q)))
		else $error("first trial order was not taken");

	a_k_limited: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pass_go && cmd.pass2) |-> (k_q <= rice_max_q))
		else $error("Rice parameter above its limit in the cost pass");

	a_read_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(cmd.pass_go))
		else $error("read data arrived without a pass");

endmodule

// ----- hdl/partitioned_rice_parameter_search.sv -----
// Partitioned Rice parameter search.
//
// Samples arrive on the input channel (in_valid, in_ready, sample, last), one
// word per cycle while the block is loading. A word with last set ends the
// sub-block and starts the search; in_ready stays low until every result word
// has been taken. Samples beyond MAX_SAMPLES are dropped.
// For each trial order the datapath makes two passes over each partition held
// in the sample memory (one memory read per cycle), with the Rice parameter
// search between them; a blank partition gets only the first pass.
// The result channel (out_valid, out_ready, kind, index, value, bit_total,
// last_result) then gives the chosen order and its total, followed by one word
// per partition; last_result marks the final word. A stalled receiver simply
// holds the current word; the block waits with it.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while
// idle; the block does not enforce it. After reset the block is loading,
// the sample count is zero and the registers hold their default values.
module partitioned_rice_parameter_search #(
	parameter int unsigned MAX_SAMPLES = 4096,
	parameter int unsigned MAX_ORDER   = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [prps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [31:0]              sample,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            kind,
	output logic [3:0]                      index,
	output logic [4:0]                      value,
	output logic [31:0]                     bit_total,
	output logic                            last_result
);

	// The controller sequences loading, the per-order partition loop and the
	// result words; the datapath holds the memory, the sums and the best trial.
	prps_pkg::cmd_t cmd;
	prps_pkg::sts_t sts;

	prps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	prps_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_ORDER   (MAX_ORDER)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (sample),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.index       (index),
		.value       (value),
		.bit_total   (bit_total),
		.last_result (last_result)
	);

endmodule
